// ===== design/sqm_pkg.sv =====
// ----------------------------------------------------------------------------
// sqm_pkg
// shared types for the square matrix multiplier: payload structs, the token
// that travels along the cell chain and the sequencer state encoding
// ----------------------------------------------------------------------------
package sqm_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned ProdW = 32;
  localparam int unsigned AccW  = 34;

  typedef struct packed {
    logic signed [ElemW-1:0] a_element;
    logic signed [ElemW-1:0] b_element;
  } sqm_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_element;
    logic                   last_element;
  } sqm_out_t;

  // control part of a token moving down the chain
  typedef struct packed {
    logic valid;
    logic last;
  } sqm_tok_t;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } sqm_state_e;

endpackage

// ===== design/sqm_cell.sv =====
// ----------------------------------------------------------------------------
// sqm_cell
// one cell of the chain: holds column k of the left matrix and row k of the
// right matrix, adds its term to the passing partial sum
// ----------------------------------------------------------------------------
module sqm_cell import sqm_pkg::*; #(
  parameter int unsigned DIM      = 4,
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned IdxW    = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_en_i,
  input  logic [IdxW-1:0]        load_row_i,
  input  logic [IdxW-1:0]        load_col_i,
  input  sqm_in_t                load_data_i,
  input  sqm_tok_t               tok_i,
  input  logic [IdxW-1:0]        row_i,
  input  logic [IdxW-1:0]        col_i,
  input  logic signed [AccW-1:0] acc_i,
  output sqm_tok_t               tok_o,
  output logic [IdxW-1:0]        row_o,
  output logic [IdxW-1:0]        col_o,
  output logic signed [AccW-1:0] acc_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic signed [ElemW-1:0] a_col_q [DIM];
  logic signed [ElemW-1:0] b_row_q [DIM];
  logic signed [ElemW-1:0] a_rd, b_rd;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc_d;

  sqm_tok_t               tok_q;
  logic [IdxW-1:0]        row_q, col_q;
  logic signed [AccW-1:0] acc_q;

  // element (r,c) of the left matrix lives in cell c, of the right in cell r
  always_ff @(posedge clk_i) begin
    if (load_en_i && (load_col_i == MyIdx)) begin
      a_col_q[load_row_i] <= load_data_i.a_element;
    end
    if (load_en_i && (load_row_i == MyIdx)) begin
      b_row_q[load_col_i] <= load_data_i.b_element;
    end
  end

  assign a_rd  = a_col_q[row_i];
  assign b_rd  = b_row_q[col_i];
  assign prod  = a_rd * b_rd;
  assign acc_d = acc_i + {{(AccW-ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_i;
    col_q <= col_i;
    acc_q <= acc_d;
  end

  assign tok_o = tok_q;
  assign row_o = row_q;
  assign col_o = col_q;
  assign acc_o = acc_q;

endmodule

// ===== design/sqm_seq.sv =====
// ----------------------------------------------------------------------------
// sqm_seq
// sequencer: load position counters, token issue for every product element
// and the busy flag covering issue and drain
// ----------------------------------------------------------------------------
module sqm_seq import sqm_pkg::*; #(
  parameter int unsigned DIM   = 4,
  localparam int unsigned IdxW = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            done_i,
  output logic            busy,
  output logic            load_en_o,
  output logic [IdxW-1:0] load_row_o,
  output logic [IdxW-1:0] load_col_o,
  output sqm_tok_t        tok_o,
  output logic [IdxW-1:0] row_o,
  output logic [IdxW-1:0] col_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIM - 1);

  sqm_state_e      state_q, state_d;
  logic [IdxW-1:0] lrow_q, lrow_d, lcol_q, lcol_d;
  logic [IdxW-1:0] irow_q, irow_d, icol_q, icol_d;
  logic            accept, iss_last;

  assign accept   = start && (state_q == ST_LOAD);
  assign iss_last = (irow_q == LastIdx) && (icol_q == LastIdx);

  always_comb begin
    state_d = state_q;
    lrow_d  = lrow_q;
    lcol_d  = lcol_q;
    irow_d  = irow_q;
    icol_d  = icol_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (lcol_q == LastIdx) begin
            lcol_d = '0;
            if (lrow_q == LastIdx) begin
              lrow_d  = '0;
              state_d = ST_ISSUE;
            end else begin
              lrow_d = lrow_q + 1'b1;
            end
          end else begin
            lcol_d = lcol_q + 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        if (icol_q == LastIdx) begin
          icol_d = '0;
          if (irow_q == LastIdx) begin
            irow_d  = '0;
            state_d = ST_DRAIN;
          end else begin
            irow_d = irow_q + 1'b1;
          end
        end else begin
          icol_d = icol_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (done_i) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      lrow_q  <= '0;
      lcol_q  <= '0;
      irow_q  <= '0;
      icol_q  <= '0;
    end else begin
      state_q <= state_d;
      lrow_q  <= lrow_d;
      lcol_q  <= lcol_d;
      irow_q  <= irow_d;
      icol_q  <= icol_d;
    end
  end

  assign busy       = (state_q != ST_LOAD);
  assign load_en_o  = accept;
  assign load_row_o = lrow_q;
  assign load_col_o = lcol_q;
  assign tok_o.valid = (state_q == ST_ISSUE);
  assign tok_o.last  = (state_q == ST_ISSUE) && iss_last;
  assign row_o      = irow_q;
  assign col_o      = icol_q;

endmodule

// ===== design/square_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// square_matrix_multiply
// DIM by DIM signed Q8.8 matrix multiplier built as a chain of DIM cells;
// products come out row-major as signed Q18.16 in 34 bits
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         start && !busy             in_i     (a_element, b_element)
//  result    out        valid_o, one-cycle strobe  result_o (product_element,
//                                                            last_element)
//
//  - one element pair is taken per cycle while busy is low, DIM*DIM in all
//  - after the last pair busy rises: DIM*DIM tokens enter the chain, one a
//    cycle, and each picks up one term per cell, so the first result is on
//    the ports once its token has passed the register of every cell, and the
//    rest follow one per cycle
//  - busy thus covers the issue and drain of a matrix, both carried by the
//    single chain that every product passes through
//  - reset clears the counters and the chain tokens; stored elements are kept
//    and are overwritten before they are read
//  - results cannot be held off: each one is valid for exactly one cycle
// ----------------------------------------------------------------------------
module square_matrix_multiply import sqm_pkg::*; #(
  parameter int unsigned DIM = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  sqm_in_t  in_i,
  output logic     valid_o,
  output sqm_out_t result_o
);

  localparam int unsigned IdxW = (DIM > 1) ? $clog2(DIM) : 1;

  // load side, broadcast to every cell
  logic            load_en;
  logic [IdxW-1:0] load_row, load_col;

  // token chain, index 0 is the sequencer output, index DIM the last cell
  sqm_tok_t               tok_c [DIM+1];
  logic [IdxW-1:0]        row_c [DIM+1];
  logic [IdxW-1:0]        col_c [DIM+1];
  logic signed [AccW-1:0] acc_c [DIM+1];

  logic done;

  // last product element leaving the chain ends the transaction
  assign done = tok_c[DIM].valid && tok_c[DIM].last;

  sqm_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .done_i     (done),
    .busy       (busy),
    .load_en_o  (load_en),
    .load_row_o (load_row),
    .load_col_o (load_col),
    .tok_o      (tok_c[0]),
    .row_o      (row_c[0]),
    .col_o      (col_c[0])
  );

  // partial sums start from zero at the head of the chain
  assign acc_c[0] = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    sqm_cell #(
      .DIM      (DIM),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_en_i   (load_en),
      .load_row_i  (load_row),
      .load_col_i  (load_col),
      .load_data_i (in_i),
      .tok_i       (tok_c[k]),
      .row_i       (row_c[k]),
      .col_i       (col_c[k]),
      .acc_i       (acc_c[k]),
      .tok_o       (tok_c[k+1]),
      .row_o       (row_c[k+1]),
      .col_o       (col_c[k+1]),
      .acc_o       (acc_c[k+1])
    );
  end

  // the last cell's registers drive the result transaction directly
  assign valid_o                  = tok_c[DIM].valid;
  assign result_o.product_element = acc_c[DIM];
  assign result_o.last_element    = tok_c[DIM].last;

endmodule

// ===== bench/square_matrix_multiply_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_test
// self-checking bench for the square matrix multiplier: element pairs are
// queued, fed in under random sender gaps and mirrored into a local copy of
// both matrices; each completed load yields the row-major Q18.16 products,
// which the monitor compares field by field with what the block emits
// ----------------------------------------------------------------------------
module square_matrix_multiply_test;
  import sqm_pkg::*;

  localparam int unsigned Dim        = 4;
  localparam int unsigned Cells      = Dim * Dim;
  localparam int unsigned RandomMats = 27;
  // a matrix needs its load phase and its busy phase; even with heavy sender
  // gaps all matrices finish far below this limit, so it is many times over
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = Cells + Dim + 8;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  sqm_in_t  in_i   = '0;
  logic     valid_o;
  sqm_out_t result_o;

  // element pairs waiting to be sent, front one on the bus while start is high
  sqm_in_t  pending_pairs[$];
  // products predicted for every completed load, oldest first
  sqm_out_t expected_products[$];

  // local copy of the block's element stores and load counter
  logic signed [ElemW-1:0] left_elems  [Cells];
  logic signed [ElemW-1:0] right_elems [Cells];
  int unsigned             load_pos = 0;

  int unsigned pairs_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  square_matrix_multiply #(
    .DIM(Dim)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // store an accepted pair; the pair for the last position closes the load and
  // produces the whole product matrix, row-major, flag on the final element
  task automatic load_element_pair(input sqm_in_t pair);
    longint   acc;
    sqm_out_t prod;
    left_elems[load_pos]  = pair.a_element;
    right_elems[load_pos] = pair.b_element;
    if (load_pos + 1 < Cells) begin
      load_pos++;
    end else begin
      load_pos = 0;
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          acc = 0;
          for (int k = 0; k < Dim; k++) begin
            acc += longint'(left_elems[r*Dim+k]) * longint'(right_elems[k*Dim+c]);
          end
          prod.product_element = acc[AccW-1:0];
          prod.last_element    = (r == Dim - 1) && (c == Dim - 1);
          expected_products.push_back(prod);
        end
      end
    end
  endtask

  // element flavours: full random, corner values, or small magnitudes
  function automatic logic [ElemW-1:0] random_element(input int unsigned flavour);
    logic [ElemW-1:0] corners [5];
    corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
    case (flavour)
      0: begin
        return ElemW'($urandom);
      end
      1: begin
        return corners[$urandom_range(4)];
      end
      default: begin
        return ElemW'(int'($urandom_range(1023)) - 512);
      end
    endcase
  endfunction

  // driver: a transaction completes at an edge with start high and busy low;
  // a refused item stays on the bus, otherwise the next one goes out unless
  // the sender takes a gap
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      start <= 1'b0;
      in_i  <= '0;
    end else begin
      // gap rate per phase: light, heavy, then none at all
      if (pairs_sent < 150) begin
        idle_pct = 11;
      end else if (pairs_sent < 300) begin
        idle_pct = 46;
      end else begin
        idle_pct = 0;
      end
      if (start && !busy) begin
        load_element_pair(in_i);
        void'(pending_pairs.pop_front());
        pairs_sent++;
      end
      if (start && busy) begin
        // hold the refused item as it is
      end else if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_i  <= pending_pairs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is one result transaction, matched in order
  always @(posedge clk_i) begin
    sqm_out_t want;
    if (rst_ni && valid_o) begin
      if (expected_products.size() == 0) begin
        $display("[%0t] unexpected product %0d", $realtime, result_o.product_element);
        error_count++;
      end else begin
        want = expected_products.pop_front();
        if (result_o.product_element !== want.product_element) begin
          report_mismatch("product_element", longint'(result_o.product_element),
                          longint'(want.product_element));
        end
        if (result_o.last_element !== want.last_element) begin
          report_mismatch("last_element", longint'(result_o.last_element),
                          longint'(want.last_element));
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sqm_in_t pair;
    logic [ElemW-1:0] row3 [Dim];
    logic [ElemW-1:0] cols [Dim];
    int unsigned flavour;

    // directed load: left rows are most negative, most positive, zero and a
    // mixed row; right columns are most negative, most positive, zero and one,
    // so the top corner reaches the largest sum and its neighbour the smallest
    row3 = '{16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    cols = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
    for (int p = 0; p < Cells; p++) begin
      case (p / Dim)
        0: pair.a_element = 16'sh8000;
        1: pair.a_element = 16'sh7FFF;
        2: pair.a_element = 16'sh0000;
        default: pair.a_element = row3[p % Dim];
      endcase
      pair.b_element = cols[p % Dim];
      pending_pairs.push_back(pair);
    end

    // random loads, one value flavour per matrix
    for (int m = 0; m < RandomMats; m++) begin
      flavour = $urandom_range(2);
      for (int p = 0; p < Cells; p++) begin
        pair.a_element = random_element(flavour);
        pair.b_element = random_element(flavour);
        pending_pairs.push_back(pair);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0) @(posedge clk_i);
    while (expected_products.size() != 0) @(posedge clk_i);
    // let any stray result surface before the verdict
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sqm_pkg.sv
design/sqm_cell.sv
design/sqm_seq.sv
design/square_matrix_multiply.sv
bench/square_matrix_multiply_test.sv
